### rtl/core/ple_pkg.sv
`default_nettype none

package ple_pkg;

	localparam int CAPACITY_DEF   = 16;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int REQ_W = 4;
	localparam int STS_W = 2;

	// request codes
	localparam logic [REQ_W-1:0] REQ_INS_FRONT = 4'd0;
	localparam logic [REQ_W-1:0] REQ_INS_BACK  = 4'd1;
	localparam logic [REQ_W-1:0] REQ_INS_AT    = 4'd2;
	localparam logic [REQ_W-1:0] REQ_RM_FRONT  = 4'd3;
	localparam logic [REQ_W-1:0] REQ_RM_BACK   = 4'd4;
	localparam logic [REQ_W-1:0] REQ_RM_AT     = 4'd5;
	localparam logic [REQ_W-1:0] REQ_RD_FRONT  = 4'd6;
	localparam logic [REQ_W-1:0] REQ_RD_BACK   = 4'd7;
	localparam logic [REQ_W-1:0] REQ_RD_AT     = 4'd8;
	localparam logic [REQ_W-1:0] REQ_WR_AT     = 4'd9;

	// status codes
	localparam logic [STS_W-1:0] STS_OK     = 2'd0;
	localparam logic [STS_W-1:0] STS_EMPTY  = 2'd1;
	localparam logic [STS_W-1:0] STS_BADPOS = 2'd2;
	localparam logic [STS_W-1:0] STS_FULL   = 2'd3;

	// controller to datapath commands
	typedef struct packed {
		logic load;   // capture the request fields
		logic exec;   // apply the captured request
	} ple_cmd_t;

endpackage

`default_nettype wire

### rtl/core/ple_ctrl.sv
`default_nettype none

module ple_ctrl
	import ple_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	output logic          done,
	output ple_cmd_t      cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy     = (state_q == S_EXEC);
	assign done     = done_q;
	assign cmd.load = start && (state_q == S_IDLE);
	assign cmd.exec = (state_q == S_EXEC);

	// an accepted transaction is applied in the very next cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.exec)
		else $error("accepted transaction not executed");

	// a result strobe only follows an execute cycle
	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(cmd.exec))
		else $error("result strobe without execute");

	// execute lasts exactly one cycle and is always followed by a result
	a_exec_single: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> (!cmd.exec && done))
		else $error("execute cycle malformed");

endmodule

`default_nettype wire

### rtl/core/ple_dpath.sv
`default_nettype none

module ple_dpath
	import ple_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	localparam int CW = $clog2(CAPACITY + 1),
	localparam int AW = $clog2(CAPACITY)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ple_cmd_t              cmd,
	input  wire logic [REQ_W-1:0]      req_type,
	input  wire logic [CW-1:0]         position,
	input  wire logic [DATA_WIDTH-1:0] data_word,
	output logic [DATA_WIDTH-1:0]      read_word,
	output logic [STS_W-1:0]           status,
	output logic [CW-1:0]              entry_count
);

	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	logic [REQ_W-1:0]      req_q;
	logic [CW-1:0]         pos_q;
	logic [DATA_WIDTH-1:0] word_q;
	logic [CW-1:0]         count_q;
	logic [DATA_WIDTH-1:0] read_word_q;
	logic [STS_W-1:0]      status_q;

	logic [DATA_WIDTH-1:0] cell_q   [CAPACITY];
	logic [DATA_WIDTH-1:0] shift_up [CAPACITY];
	logic [DATA_WIDTH-1:0] shift_dn [CAPACITY];

	logic                  ins_ok;
	logic                  rm_ok;
	logic                  rd_ok;
	logic                  wr_ok;
	logic [CW-1:0]         pt;
	logic [STS_W-1:0]      sts_d;
	logic [DATA_WIDTH-1:0] rd_d;

	// request capture, payload only
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= req_type;
			pos_q  <= position;
			word_q <= data_word;
		end
	end

	// decode and checks
	always_comb begin
		ins_ok = 1'b0;
		rm_ok  = 1'b0;
		rd_ok  = 1'b0;
		wr_ok  = 1'b0;
		pt     = pos_q;
		sts_d  = STS_OK;
		case (req_q) inside
			[REQ_INS_FRONT:REQ_INS_AT]: begin
				if (req_q == REQ_INS_FRONT) begin
					pt = '0;
				end else if (req_q == REQ_INS_BACK) begin
					pt = count_q;
				end
				if (pt > count_q) begin
					sts_d = STS_BADPOS;
				end else if (count_q == CAP_C) begin
					sts_d = STS_FULL;
				end else begin
					ins_ok = 1'b1;
				end
			end
			[REQ_RM_FRONT:REQ_WR_AT]: begin
				case (req_q) inside
					REQ_RM_FRONT, REQ_RD_FRONT: pt = '0;
					REQ_RM_BACK, REQ_RD_BACK:   pt = count_q - CW'(1);
					default:                    pt = pos_q;
				endcase
				if (count_q == '0) begin
					sts_d = STS_EMPTY;
				end else if (pt >= count_q) begin
					sts_d = STS_BADPOS;
				end else begin
					case (req_q) inside
						[REQ_RM_FRONT:REQ_RM_AT]: rm_ok = 1'b1;
						[REQ_RD_FRONT:REQ_RD_AT]: rd_ok = 1'b1;
						default:                  wr_ok = 1'b1;
					endcase
				end
			end
			default: begin
				sts_d = STS_OK;
			end
		endcase
	end

	assign rd_d = rd_ok ? cell_q[pt[AW-1:0]] : '0;

	// shifting cell array
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [CW-1:0] IDX = CW'(i);

		if (i == 0) begin : g_lo
			assign shift_up[i] = cell_q[i];
		end else begin : g_mid_lo
			assign shift_up[i] = cell_q[i-1];
		end

		if (i == CAPACITY - 1) begin : g_hi
			assign shift_dn[i] = cell_q[i];
		end else begin : g_mid_hi
			assign shift_dn[i] = cell_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.exec) begin
				if (ins_ok && (IDX > pt)) begin
					cell_q[i] <= shift_up[i];
				end else if ((ins_ok || wr_ok) && (IDX == pt)) begin
					cell_q[i] <= word_q;
				end else if (rm_ok && (IDX >= pt)) begin
					cell_q[i] <= shift_dn[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			if (ins_ok) begin
				count_q <= count_q + CW'(1);
			end else if (rm_ok) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			read_word_q <= rd_d;
			status_q    <= sts_d;
		end
	end

	assign read_word   = read_word_q;
	assign status      = status_q;
	assign entry_count = count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("entry count above capacity");

	a_count_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.exec |=> $stable(count_q))
		else $error("entry count moved outside execute");

	a_single_op: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> $onehot0({ins_ok, rm_ok, rd_ok, wr_ok}))
		else $error("more than one list operation decoded");

endmodule

`default_nettype wire

### rtl/core/positional_list_engine.sv
// Result path: an accepted transaction enters the execute state, where it is
//   applied; the result registers and done are written as execute ends.
// Intake: a transaction is taken only in idle, set by the load/execute pair of
//   the controller; every insert or remove is one shift of the cell array.
// Reset: arst_n clears the controller and the entry count; cell contents stay
//   undefined until written. The receiver cannot stall: done lasts one cycle.
`default_nettype none

module positional_list_engine
	import ple_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// request side: a transaction is taken when start is high and busy is low
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [REQ_W-1:0]      req_type,
	input  wire logic [CW-1:0]         position,
	input  wire logic [DATA_WIDTH-1:0] data_word,
	// result side: valid for exactly the cycle in which done is high
	output logic                       done,
	output logic [DATA_WIDTH-1:0]      read_word,
	output logic [STS_W-1:0]           status,
	output logic [CW-1:0]              entry_count
);

	// controller to datapath: load captures the request, exec applies it
	ple_cmd_t cmd;

	// Controller: idle/execute sequencer. The busy flag covers only the execute
	// cycle, so a new request can be taken while the previous result is shown.
	ple_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// Datapath: request registers, status checks, the shifting cell array that
	// holds the list (front at cell zero), the entry count and the result
	// registers. Result registers change only on execute, so they hold steady
	// through the done cycle.
	ple_dpath #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.req_type    (req_type),
		.position    (position),
		.data_word   (data_word),
		.read_word   (read_word),
		.status      (status),
		.entry_count (entry_count)
	);

endmodule

`default_nettype wire

### bench/tb_positional_list_engine.sv
`default_nettype none

module tb_positional_list_engine
	import ple_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP      = CAPACITY_DEF;
	localparam int DW       = DATA_WIDTH_DEF;
	localparam int CW       = $clog2(CAP + 1);
	localparam int N_RANDOM = 800;
	localparam int PHASE_SZ = 200;
	localparam int LIMIT    = 100000;   // watchdog limit, in cycles

	// codes 10..15 are not decoded by the block
	localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 4'd10;
	localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 4'd15;

	// request families, indexed front / back / at (access adds write)
	localparam logic [REQ_W-1:0] INS_OPS[3] = '{REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_AT};
	localparam logic [REQ_W-1:0] RM_OPS[3]  = '{REQ_RM_FRONT, REQ_RM_BACK, REQ_RM_AT};
	localparam logic [REQ_W-1:0] ACC_OPS[4] = '{REQ_RD_FRONT, REQ_RD_BACK, REQ_RD_AT,
		REQ_WR_AT};

	typedef struct packed {
		logic [DW-1:0]    rd;
		logic [STS_W-1:0] st;
		logic [CW-1:0]    cnt;
	} list_result_t;

	// one request; known marks a row whose result is typed in by hand
	typedef struct packed {
		logic [REQ_W-1:0] req;
		logic [CW-1:0]    pos;
		logic [DW-1:0]    data;
		bit               known;
		list_result_t     res;
	} list_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [REQ_W-1:0]      req_type;
	logic [CW-1:0]         position;
	logic [DW-1:0]         data_word;
	logic                  done;
	logic [DW-1:0]         read_word;
	logic [STS_W-1:0]      status;
	logic [CW-1:0]         entry_count;

	positional_list_engine #(
		.CAPACITY(CAP),
		.DATA_WIDTH(DW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.position(position),
		.data_word(data_word),
		.done(done),
		.read_word(read_word),
		.status(status),
		.entry_count(entry_count)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ------------------------------------------------------------------
	// Predictor: shadow copy of the list. Updated once per accepted
	// transaction, in acceptance order.
	// ------------------------------------------------------------------
	logic [DW-1:0] list_mem[CAP];
	int            list_len;

	function automatic list_result_t apply_list_req(logic [REQ_W-1:0] req,
		logic [CW-1:0] pos, logic [DW-1:0] word);
		list_result_t r;
		int p;
		r.rd = '0;
		r.st = STS_OK;
		case (req)
			REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_AT: begin
				p = (req == REQ_INS_FRONT) ? 0 : (req == REQ_INS_BACK) ? list_len : int'(pos);
				// position is checked before fullness
				if (p > list_len)
					r.st = STS_BADPOS;
				else if (list_len >= CAP)
					r.st = STS_FULL;
				else begin
					for (int i = list_len; i > p; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[p] = word;
					list_len++;
				end
			end
			REQ_RM_FRONT, REQ_RM_BACK, REQ_RM_AT,
			REQ_RD_FRONT, REQ_RD_BACK, REQ_RD_AT, REQ_WR_AT: begin
				// empty wins over a bad position
				if (list_len == 0)
					r.st = STS_EMPTY;
				else begin
					case (req)
						REQ_RM_FRONT, REQ_RD_FRONT: p = 0;
						REQ_RM_BACK, REQ_RD_BACK:   p = list_len - 1;
						default:                    p = int'(pos);
					endcase
					if (p >= list_len)
						r.st = STS_BADPOS;
					else if (req == REQ_RM_FRONT || req == REQ_RM_BACK || req == REQ_RM_AT) begin
						for (int i = p; i + 1 < list_len; i++)
							list_mem[i] = list_mem[i+1];
						list_len--;
					end else if (req == REQ_WR_AT)
						list_mem[p] = word;
					else
						r.rd = list_mem[p];
				end
			end
			default: ;   // unused code: no effect, status ok
		endcase
		r.cnt = CW'(list_len);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Scoreboard
	// ------------------------------------------------------------------
	list_result_t pending_q[$];   // expected results, oldest first
	list_row_t    issued_q[$];    // driven rows awaiting acceptance
	int           err_cnt;
	int           txn_cnt;
	int           status_hits[4];

	task automatic check_field(string name, logic [DW-1:0] want, logic [DW-1:0] got);
		if (got !== want) begin
			err_cnt++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	// everything sampled at the rising edge sees pre-edge values
	always @(posedge clk) begin
		list_result_t want;
		list_row_t    row;
		if (arst_n) begin
			if (done) begin
				if (pending_q.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected result, expected none, actual rd %h st %0d cnt %0d",
						$time, read_word, status, entry_count);
				end else begin
					want = pending_q.pop_front();
					check_field("read_word", want.rd, read_word);
					check_field("status", DW'(want.st), DW'(status));
					check_field("entry_count", DW'(want.cnt), DW'(entry_count));
					status_hits[want.st]++;
				end
			end
			if (start && !busy) begin
				// predictor always runs so its state tracks the block
				want = apply_list_req(req_type, position, data_word);
				row = issued_q.pop_front();
				if (row.known)
					want = row.res;
				pending_q.push_back(want);
				txn_cnt++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------
	int cycle_cnt;

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("%0t: timeout after %0d cycles", $time, LIMIT);
		$display("positional_list_engine verification failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Driver: fields change at the falling edge; start stays high across
	// back-to-back transactions.
	// ------------------------------------------------------------------
	task automatic issue(list_row_t row);
		@(negedge clk);
		start     <= 1'b1;
		req_type  <= row.req;
		position  <= row.pos;
		data_word <= row.data;
		issued_q.push_back(row);
		do
			@(posedge clk);
		while (busy !== 1'b0);
	endtask

	// sender pause: hold start low until every result has come back
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
	endtask

	// Directed rows. Hand-typed results only after reset, at the edges and
	// on error codes; the rest go through the predictor.
	localparam int N_DIR = 24;
	localparam list_row_t DIR_ROWS[N_DIR] = '{
		// on the empty list after reset
		'{REQ_RD_FRONT,  5'd0,  32'h1234_5678, 1'b1, '{32'h0, STS_EMPTY,  5'd0}},
		'{REQ_RM_BACK,   5'd0,  32'h0,         1'b1, '{32'h0, STS_EMPTY,  5'd0}},
		'{REQ_WR_AT,     5'd0,  32'hFFFF_FFFF, 1'b1, '{32'h0, STS_EMPTY,  5'd0}},
		'{REQ_INS_AT,    5'd1,  32'hFFFF_FFFF, 1'b1, '{32'h0, STS_BADPOS, 5'd0}},
		'{REQ_UNUSED_HI, 5'd31, 32'hFFFF_FFFF, 1'b1, '{32'h0, STS_OK,     5'd0}},
		// build a short list
		'{REQ_INS_FRONT, 5'd0,  32'hFFFF_FFFF, 1'b1, '{32'h0, STS_OK,     5'd1}},
		'{REQ_INS_BACK,  5'd0,  32'h0,         1'b1, '{32'h0, STS_OK,     5'd2}},
		'{REQ_INS_AT,    5'd1,  32'hA5A5_A5A5, 1'b0, '0},
		'{REQ_RD_AT,     5'd1,  32'hFFFF_FFFF, 1'b0, '0},
		'{REQ_RD_FRONT,  5'd0,  32'h0,         1'b0, '0},
		'{REQ_RD_BACK,   5'd0,  32'h0,         1'b0, '0},
		// positions at or past the end, then edits and reads inside the list
		'{REQ_WR_AT,     5'd3,  32'h5555_5555, 1'b1, '{32'h0, STS_BADPOS, 5'd3}},
		'{REQ_INS_AT,    5'd31, 32'h5555_5555, 1'b1, '{32'h0, STS_BADPOS, 5'd3}},
		'{REQ_INS_AT,    5'd3,  32'h5A5A_5A5A, 1'b0, '0},
		'{REQ_RM_AT,     5'd0,  32'h0,         1'b0, '0},
		'{REQ_RD_AT,     5'd16, 32'h0,         1'b1, '{32'h0, STS_BADPOS, 5'd3}},
		'{REQ_WR_AT,     5'd2,  32'h0F0F_0F0F, 1'b0, '0},
		'{REQ_RD_AT,     5'd2,  32'h0,         1'b0, '0},
		'{REQ_UNUSED_LO, 5'd0,  32'hFFFF_FFFF, 1'b1, '{32'h0, STS_OK,     5'd3}},
		// empty it again from every side
		'{REQ_RM_FRONT,  5'd0,  32'h0,         1'b0, '0},
		'{REQ_RM_BACK,   5'd0,  32'h0,         1'b0, '0},
		'{REQ_RM_AT,     5'd0,  32'h0,         1'b0, '0},
		'{REQ_RM_AT,     5'd0,  32'h0,         1'b1, '{32'h0, STS_EMPTY,  5'd0}},
		'{REQ_RD_BACK,   5'd0,  32'h0,         1'b1, '{32'h0, STS_EMPTY,  5'd0}}
	};

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		list_row_t row;
		int        phase;
		int        idle_pct;
		int        mode;
		int        pick;
		int        ins_w;
		int        rm_w;
		bit        is_ins;

		start     = 1'b0;
		req_type  = '0;
		position  = '0;
		data_word = '0;
		arst_n    = 1'b0;
		list_len  = 0;
		err_cnt   = 0;
		txn_cnt   = 0;
		status_hits = '{0, 0, 0, 0};

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		for (int k = 0; k < N_DIR; k++)
			issue(DIR_ROWS[k]);
		drain();

		// Random part. Phases: no gaps, heavy gaps (63%), light gaps (17%),
		// no gaps. Every 50 transactions the mix swings between filling,
		// draining and balanced so the list hits full and empty repeatedly.
		for (int i = 0; i < N_RANDOM; i++) begin
			phase = i / PHASE_SZ;
			if (i != 0 && i % PHASE_SZ == 0)
				drain();
			idle_pct = (phase == 1) ? 63 : (phase == 2) ? 17 : 0;
			if ($urandom_range(0, 99) < idle_pct) begin
				@(negedge clk);
				start <= 1'b0;
				repeat ($urandom_range(0, 4)) @(negedge clk);
			end

			mode  = (i / 50) % 3;
			ins_w = (mode == 0) ? 70 : (mode == 1) ? 15 : 35;
			rm_w  = (mode == 0) ? 10 : (mode == 1) ? 60 : 30;
			row   = '0;
			if ($urandom_range(0, 99) < 8) begin
				// noise: any code, any position
				row.req = REQ_W'($urandom_range(0, 15));
				row.pos = CW'($urandom_range(0, 31));
			end else begin
				pick   = $urandom_range(0, 99);
				is_ins = (pick < ins_w);
				if (is_ins)
					row.req = INS_OPS[$urandom_range(0, 2)];
				else if (pick < ins_w + rm_w)
					row.req = RM_OPS[$urandom_range(0, 2)];
				else
					row.req = ACC_OPS[$urandom_range(0, 3)];
				if ($urandom_range(0, 9) == 0)
					row.pos = CW'($urandom_range(0, 31));
				else if (is_ins)
					row.pos = CW'($urandom_range(0, list_len));
				else if (list_len > 0)
					row.pos = CW'($urandom_range(0, list_len - 1));
			end
			case ($urandom_range(0, 7))
				0:       row.data = '0;
				1:       row.data = '1;
				2:       row.data = DW'(1) << $urandom_range(0, DW - 1);
				default: row.data = DW'($urandom);
			endcase
			issue(row);
		end

		drain();
		repeat (6) @(posedge clk);

		$display("ran %0d transactions (%0d directed, %0d random) with gap phases",
			txn_cnt, N_DIR, N_RANDOM);
		$display("status seen: ok %0d, empty %0d, bad position %0d, full %0d",
			status_hits[STS_OK], status_hits[STS_EMPTY], status_hits[STS_BADPOS],
			status_hits[STS_FULL]);
		if (err_cnt == 0)
			$display("positional_list_engine verification clean");
		else
			$display("positional_list_engine verification failed");
		$finish;
	end

endmodule

`default_nettype wire
